/* rtl/core/prt_pkg.sv */
// package for the proximity route table: widths, codes, entry layout, states
// no dependencies; used by the interfaces and the top level
package prt_pkg;

   localparam int PRT_CAPACITY  = 16;
   localparam int RING_ID_W     = 64;
   localparam int NET_ADDR_W    = 32;
   localparam int DELAY_W       = 20;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 64;

   localparam logic [DELAY_W-1:0] NO_EVICT_LATENCY = DELAY_W'(1000000);

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // lookup modes
   localparam logic MODE_LATENCY  = 1'b0;
   localparam logic MODE_DISTANCE = 1'b1;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MY_ID       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKUP_MODE = CSR_IDX_W'(1);

   typedef struct packed {
      logic [RING_ID_W-1:0]  ring_id;
      logic [NET_ADDR_W-1:0] net_addr;
      logic [DELAY_W-1:0]    delay;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVSCAN,
      ST_SHIFT,
      ST_LOOKUP,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/prt_intf.sv */
// channel interfaces of the proximity route table: request, response, csr write
// depends on prt_pkg for field widths
interface prt_req_if;
   import prt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [RING_ID_W-1:0]  node_id;
   logic [NET_ADDR_W-1:0] node_address;
   logic [DELAY_W-1:0]    latency;
   logic [RING_ID_W-1:0]  lookup_key;

   modport source (output valid, kind, node_id, node_address, latency, lookup_key,
                   input ready);
   modport sink   (input valid, kind, node_id, node_address, latency, lookup_key,
                   output ready);
endinterface

interface prt_rsp_if;
   import prt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [RING_ID_W-1:0]  hop_id;
   logic [NET_ADDR_W-1:0] hop_address;
   logic                  accepted;
   logic                  evicted;
   logic [DELAY_W-1:0]    evicted_latency;

   modport source (output valid, found, hop_id, hop_address, accepted, evicted,
                   evicted_latency, input ready);
   modport sink   (input valid, found, hop_id, hop_address, accepted, evicted,
                   evicted_latency, output ready);
endinterface

interface prt_csr_if;
   import prt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/core/prt_ram.sv */
// generic one-write one-read ram with registered read data
// no dependencies
module prt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/proximity_route_table_top.sv */
// top level of the proximity route table: sequencer, scan compare unit, result register
// depends on prt_pkg, the prt_*_if interfaces and prt_ram
//
// usage
//   req beat: kind 0 inserts (node_id, node_address, latency), kind 1 looks up lookup_key
//   rsp beat: exactly one per request beat, in request order
//   csr beat: index 0 writes my_id, index 1 writes lookup_mode (bit 0); other indexes
//     are ignored; csr ready is always high, write only while the table is idle
// timing
//   req ready is high only in idle, so a new request is taken only once the last one is done
//   the table sits in one ram read one entry per cycle by a single compare unit
//   lookup: reads the live entries in turn, then moves to done and loads the response
//   insert that fits, or refused insert: written (when it fits) in idle, then done
//   insert into a full table: appended to the spare slot, eviction scan over every slot,
//     compaction of the entries behind the evicted one, then done
// reset
//   synchronous, active high; count goes to 0, threshold to 1000000, my_id and
//   lookup_mode to 0; the ram is not cleared, only slots already written are read
// stall
//   the finished response waits in an output register; while one still waits and rsp
//   ready is low the sequencer holds in its done state and takes no new request
module proximity_route_table_top #(
   parameter int CAPACITY = prt_pkg::PRT_CAPACITY
) (
   input logic      clock,
   input logic      reset,
   prt_req_if.sink   req_bus,
   prt_rsp_if.source rsp_bus,
   prt_csr_if.sink   csr_bus
);
   import prt_pkg::*;

   localparam int SLOTS = CAPACITY + 1;            // one spare slot for the append
   localparam int IW    = $clog2(SLOTS);           // slot address width
   localparam int CW    = $clog2(SLOTS + 1);       // counter width, holds SLOTS
   localparam int EW    = $bits(entry_type);

   // control state
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff;
   logic [DELAY_W-1:0]   thresh_ff;
   logic [RING_ID_W-1:0] my_id_ff;
   logic                 mode_ff;

   // scan pointer and read pipeline
   logic [CW-1:0]        scan_idx_ff;
   logic [CW-1:0]        scan_lim_ff;
   logic                 data_vld_ff;
   logic [IW-1:0]        data_idx_ff;

   // request snapshot
   logic                 kind_ff;
   logic [RING_ID_W-1:0] key_ff;
   logic                 arc_lt_ff;                // my_id < key: arc does not wrap

   // running best of the scan
   logic                 have_ff;
   logic                 ins_ok_ff;
   logic                 evict_ff;
   logic [DELAY_W-1:0]   best_lat_ff;
   logic [RING_ID_W-1:0] best_dist_ff;
   logic [IW-1:0]        worst_ff;
   logic [RING_ID_W-1:0] pick_id_ff;
   logic [NET_ADDR_W-1:0] pick_addr_ff;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [RING_ID_W-1:0]  rsp_hop_id_ff;
   logic [NET_ADDR_W-1:0] rsp_hop_addr_ff;
   logic                  rsp_accepted_ff;
   logic                  rsp_evicted_ff;
   logic [DELAY_W-1:0]    rsp_ev_lat_ff;

   // ram ports
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   // handshake and decode
   logic          req_fire;
   logic          rsp_fire;
   logic          rsp_load;
   logic          admit;
   logic          table_full;
   logic          scan_busy;
   logic          scan_over;

   // shared compare unit
   logic                 eligible;
   logic [RING_ID_W-1:0] ring_gap;
   logic                 take_lookup;
   logic                 take_worst;

   // result build
   logic          res_found;

   prt_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_fire   = req_bus.valid && req_bus.ready;
   assign rsp_fire   = rsp_valid_ff && rsp_bus.ready;
   assign table_full = (count_ff == CW'(CAPACITY));
   // refuse only when full and not under the last eviction latency
   assign admit      = (req_bus.latency < thresh_ff) || !table_full;
   assign scan_busy  = (scan_idx_ff < scan_lim_ff);
   assign scan_over  = !scan_busy && !data_vld_ff;
   assign rd_addr    = scan_idx_ff[IW-1:0];

   // eligibility: id in (my_id, key], whole ring when my_id == key
   assign eligible = arc_lt_ff ?
                     ((rd_data.ring_id > my_id_ff) && (rd_data.ring_id <= key_ff)) :
                     ((rd_data.ring_id > my_id_ff) || (rd_data.ring_id <= key_ff));
   assign ring_gap = key_ff - rd_data.ring_id;

   always_comb begin
      take_lookup = 1'b0;
      if (eligible) begin
         if (mode_ff == MODE_DISTANCE) begin
            take_lookup = !have_ff || (ring_gap < best_dist_ff);
         end else begin
            take_lookup = !have_ff || (rd_data.delay > best_lat_ff);
         end
      end
   end

   // first greatest latency wins, strict compare keeps the earliest
   assign take_worst = (data_idx_ff == '0) || (rd_data.delay > best_lat_ff);

   // sequencer: next state and control outputs
   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IW-1:0];
      wr_data       = '{ring_id:  req_bus.node_id,
                        net_addr: req_bus.node_address,
                        delay:    req_bus.latency};
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               if (req_bus.kind == KIND_INSERT) begin
                  // append goes straight into the free slot
                  wr_en    = admit;
                  state_in = (admit && table_full) ? ST_EVSCAN : ST_DONE;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_EVSCAN: begin
            rd_en = scan_busy;
            if (scan_over) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // read slot j, write it back at j - 1 in the next cycle
            rd_en = scan_busy;
            if (data_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = data_idx_ff - IW'(1);
               wr_data = rd_data;
            end
            if (scan_over) begin
               state_in = ST_DONE;
            end
         end
         ST_LOOKUP: begin
            rd_en = scan_busy;
            if (scan_over) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // csr registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff <= '0;
         mode_ff  <= MODE_LATENCY;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MY_ID:       my_id_ff <= csr_bus.wdata;
            CSR_LOOKUP_MODE: mode_ff  <= csr_bus.wdata[0];
            default: begin
            end
         endcase
      end
   end

   // table count, admit threshold, read pipeline valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         thresh_ff   <= NO_EVICT_LATENCY;
         data_vld_ff <= 1'b0;
      end else begin
         data_vld_ff <= rd_en;
         if (req_fire && req_bus.kind == KIND_INSERT && admit && !table_full) begin
            count_ff  <= count_ff + CW'(1);
            thresh_ff <= NO_EVICT_LATENCY;
         end
         if (state_ff == ST_SHIFT && scan_over) begin
            thresh_ff <= best_lat_ff;
         end
      end
   end

   // scan pointer, request snapshot and running best
   always_ff @(posedge clock) begin
      if (rd_en) begin
         scan_idx_ff <= scan_idx_ff + CW'(1);
         data_idx_ff <= rd_addr;
      end
      if (req_fire) begin
         kind_ff     <= req_bus.kind;
         key_ff      <= req_bus.lookup_key;
         arc_lt_ff   <= (my_id_ff < req_bus.lookup_key);
         have_ff     <= 1'b0;
         ins_ok_ff   <= admit;
         evict_ff    <= admit && table_full;
         best_lat_ff <= '0;
         scan_idx_ff <= '0;
         // lookups walk the live entries, eviction walks every slot
         scan_lim_ff <= (req_bus.kind == KIND_INSERT) ? CW'(SLOTS) : count_ff;
      end
      if (state_ff == ST_EVSCAN) begin
         if (data_vld_ff && take_worst) begin
            best_lat_ff <= rd_data.delay;
            worst_ff    <= data_idx_ff;
         end
         if (scan_over) begin
            scan_idx_ff <= CW'(worst_ff) + CW'(1);
            scan_lim_ff <= CW'(SLOTS);
         end
      end
      if (state_ff == ST_LOOKUP && data_vld_ff && take_lookup) begin
         have_ff      <= 1'b1;
         best_lat_ff  <= rd_data.delay;
         best_dist_ff <= ring_gap;
         pick_id_ff   <= rd_data.ring_id;
         pick_addr_ff <= rd_data.net_addr;
      end
   end

   // latency mode needs a nonzero best latency to count as a hit
   assign res_found = (kind_ff == KIND_LOOKUP) && have_ff &&
                      ((mode_ff == MODE_DISTANCE) || (best_lat_ff != '0));

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff    <= res_found;
         rsp_hop_id_ff   <= res_found ? pick_id_ff : '0;
         rsp_hop_addr_ff <= res_found ? pick_addr_ff : '0;
         rsp_accepted_ff <= (kind_ff == KIND_INSERT) && ins_ok_ff;
         rsp_evicted_ff  <= (kind_ff == KIND_INSERT) && evict_ff;
         rsp_ev_lat_ff   <= ((kind_ff == KIND_INSERT) && evict_ff) ?
                            best_lat_ff : NO_EVICT_LATENCY;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.found           = rsp_found_ff;
   assign rsp_bus.hop_id          = rsp_hop_id_ff;
   assign rsp_bus.hop_address     = rsp_hop_addr_ff;
   assign rsp_bus.accepted        = rsp_accepted_ff;
   assign rsp_bus.evicted         = rsp_evicted_ff;
   assign rsp_bus.evicted_latency = rsp_ev_lat_ff;

`ifndef NO_ASSERTIONS
   // live count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // compaction writes stay below the spare slot
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && wr_en) |-> (wr_addr < IW'(CAPACITY)))
      else $error("compaction write outside live slots");

   // a request beat always starts work, never returns straight to idle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request beat did not start work");

   // leaving done always leaves a response waiting
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("done state left without a response");

   // an eviction always marks the insert as taken
   a_evict_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bus.evicted) |-> rsp_bus.accepted)
      else $error("eviction reported on a refused insert");
`endif

endmodule
